/* rtl/core/gmap_pkg.sv */
// Shared constants and types for the grid maximum average path block.
package gmap_pkg;

    localparam int CFG_W     = 7;
    localparam int SUM_OUT_W = 23;
    localparam int AVG_OUT_W = 24;

    typedef enum logic [2:0] {
        BK_IDLE = 3'b001,
        BK_DIV  = 3'b010,
        BK_DONE = 3'b100
    } back_state_t;

endpackage

/* rtl/core/gmap_front.sv */
// Front end: accepts cells, tracks the grid position and updates the best path sums.
module gmap_front
    import gmap_pkg::*;
#(
    parameter int MAX_SIZE    = 64,
    parameter int VALUE_WIDTH = 16,
    parameter int IDX_W       = 6,
    parameter int SUM_W       = 23,
    parameter int DIV_W       = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          grid_size_we,
    input  logic [CFG_W-1:0]              grid_size,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [VALUE_WIDTH-1:0] cell_value,
    input  logic                          q_full,
    output logic                          q_push,
    output logic signed [SUM_W-1:0]       q_sum,
    output logic [DIV_W-1:0]              q_div
);

    logic [IDX_W-1:0]        col_reg, col_next;
    logic [IDX_W-1:0]        row_reg, row_next;
    logic [IDX_W-1:0]        last_reg, last_next;
    logic [DIV_W-1:0]        div_reg, div_next;
    logic signed [SUM_W-1:0] left_reg, left_next;
    logic signed [SUM_W-1:0] above_reg;
    logic signed [SUM_W-1:0] row_mem [MAX_SIZE];
    logic signed [SUM_W-1:0] cell_ext;
    logic signed [SUM_W-1:0] best;
    logic                    col_end;
    logic                    is_last;
    logic                    accept;

    assign col_end  = (col_reg == last_reg);
    assign is_last  = col_end && (row_reg == last_reg);
    // Only the closing cell of a grid needs room in the result queue.
    assign in_stall = q_full && is_last;
    assign accept   = in_valid && !in_stall;
    assign cell_ext = SUM_W'(cell_value);

    always_comb
    begin
        priority if (row_reg == '0 && col_reg == '0)
        begin
            best = cell_ext;
        end
        else if (row_reg == '0)
        begin
            best = left_reg + cell_ext;
        end
        else if (col_reg == '0)
        begin
            best = above_reg + cell_ext;
        end
        else
        begin
            best = ((above_reg > left_reg) ? above_reg : left_reg) + cell_ext;
        end
    end

    always_comb
    begin
        int side;
        side = (grid_size == '0) ? 1 :
               ((int'(grid_size) > MAX_SIZE) ? MAX_SIZE : int'(grid_size));
        col_next  = col_reg;
        row_next  = row_reg;
        left_next = left_reg;
        last_next = last_reg;
        div_next  = div_reg;
        if (grid_size_we)
        begin
            last_next = IDX_W'(side - 1);
            div_next  = DIV_W'(2 * side - 1);
            col_next  = '0;
            row_next  = '0;
            left_next = '0;
        end
        else if (accept)
        begin
            left_next = best;
            if (col_end)
            begin
                col_next = '0;
                if (row_reg == last_reg)
                begin
                    row_next  = '0;
                    left_next = '0;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            left_reg <= '0;
            last_reg <= '0;
            div_reg  <= DIV_W'(1);
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            left_reg <= left_next;
            last_reg <= last_next;
            div_reg  <= div_next;
        end
    end

    // The row store is read into a register at the column of the next cell, ahead of that cell.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_mem[col_reg] <= best;
        end
        above_reg <= row_mem[col_next];
    end

    assign q_push = accept && is_last;
    assign q_sum  = best;
    assign q_div  = div_reg;

endmodule

/* rtl/core/gmap_fifo.sv */
// Two-entry queue that carries finished grid sums from the front end to the divider.
module gmap_fifo #(
    parameter int WIDTH = 30
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/core/gmap_back.sv */
// Back end: divides the best sum by the path length, one quotient bit per cycle.
module gmap_back
    import gmap_pkg::*;
#(
    parameter int SUM_W         = 23,
    parameter int DIV_W         = 7,
    parameter int FRACTION_BITS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  logic signed [SUM_W-1:0]     q_sum,
    input  logic [DIV_W-1:0]            q_div,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [SUM_OUT_W-1:0] best_path_sum,
    output logic signed [AVG_OUT_W-1:0] average_q8
);

    localparam int DVD_W   = SUM_W + FRACTION_BITS;
    localparam int CNT_W   = $clog2(DVD_W + 1);
    localparam int SEXT_W  = (SUM_W > SUM_OUT_W) ? SUM_W : SUM_OUT_W;
    localparam int AEXT_W  = (DVD_W + 1 > AVG_OUT_W) ? DVD_W + 1 : AVG_OUT_W;

    back_state_t             state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [SUM_W-1:0] sum_reg;
    logic [DIV_W-1:0]        div_reg;
    logic [DIV_W-1:0]        rem_reg;
    logic [DVD_W-1:0]        dvd_reg;
    logic                    neg_reg;
    logic [SUM_W-1:0]        mag;
    logic [DIV_W:0]          trial;
    logic                    fits;
    logic signed [DVD_W:0]   quot;
    logic signed [SEXT_W-1:0] sum_ext;
    logic signed [AEXT_W-1:0] avg_ext;

    assign q_pop = (state_reg == BK_IDLE) && q_valid;
    assign mag   = (q_sum < 0) ? SUM_W'(-q_sum) : SUM_W'(q_sum);
    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits  = (trial >= {1'b0, div_reg});

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = BK_DIV;
                    cnt_next   = CNT_W'(DVD_W);
                end
            end
            BK_DIV:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Restoring division: the dividend register fills with quotient bits from the bottom.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            sum_reg <= q_sum;
            div_reg <= q_div;
            neg_reg <= (q_sum < 0);
            rem_reg <= '0;
            dvd_reg <= DVD_W'(mag) << FRACTION_BITS;
        end
        else if (state_reg == BK_DIV)
        begin
            rem_reg <= fits ? DIV_W'(trial - {1'b0, div_reg}) : DIV_W'(trial);
            dvd_reg <= {dvd_reg[DVD_W-2:0], fits};
        end
    end

    assign quot    = neg_reg ? -$signed({1'b0, dvd_reg}) : $signed({1'b0, dvd_reg});
    assign sum_ext = SEXT_W'(sum_reg);
    assign avg_ext = AEXT_W'(quot);

    assign out_valid     = (state_reg == BK_DONE);
    assign best_path_sum = sum_ext[SUM_OUT_W-1:0];
    assign average_q8    = avg_ext[AVG_OUT_W-1:0];

endmodule

/* rtl/core/grid_max_average_path.sv */
// Top level of the grid maximum average path block.
// A cell request is taken every cycle; the front end only stalls on a grid's last cell when the
// result queue is full. The best sum and its path length pass through the two-entry result queue
// to the bit-serial divider, which takes a new grid only from its idle state, so not before the
// last result has been accepted. Reset clears counters, queue and divider state and sets
// the side length to 1; the row store is not cleared.
module grid_max_average_path
    import gmap_pkg::*;
#(
    parameter int MAX_SIZE      = 64,
    parameter int VALUE_WIDTH   = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          grid_size_we,
    input  logic [CFG_W-1:0]              grid_size,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [VALUE_WIDTH-1:0] cell_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SUM_OUT_W-1:0]   best_path_sum,
    output logic signed [AVG_OUT_W-1:0]   average_q8
);

    localparam int IDX_W = $clog2(MAX_SIZE);
    localparam int DIV_W = IDX_W + 1;
    localparam int SUM_W = VALUE_WIDTH + $clog2(2 * MAX_SIZE);
    localparam int Q_W   = SUM_W + DIV_W;

    logic                    q_full;
    logic                    q_push;
    logic signed [SUM_W-1:0] push_sum;
    logic [DIV_W-1:0]        push_div;
    logic                    q_pop;
    logic                    q_not_empty;
    logic [Q_W-1:0]          pop_data;

    gmap_front #(
        .MAX_SIZE    (MAX_SIZE),
        .VALUE_WIDTH (VALUE_WIDTH),
        .IDX_W       (IDX_W),
        .SUM_W       (SUM_W),
        .DIV_W       (DIV_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .grid_size_we (grid_size_we),
        .grid_size    (grid_size),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cell_value   (cell_value),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_sum        (push_sum),
        .q_div        (push_div)
    );

    gmap_fifo #(
        .WIDTH (Q_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_sum, push_div}),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (pop_data)
    );

    gmap_back #(
        .SUM_W         (SUM_W),
        .DIV_W         (DIV_W),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_not_empty),
        .q_sum         ($signed(pop_data[Q_W-1:DIV_W])),
        .q_div         (pop_data[DIV_W-1:0]),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .best_path_sum (best_path_sum),
        .average_q8    (average_q8)
    );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for grid_max_average_path: streamed grids against a path-sum predictor.
module tb_top
    import gmap_pkg::*;
();

    localparam int MAX_SIDE     = 64;
    localparam int BIG_SIDE     = 16;
    localparam int FRAC_BITS    = 8;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_CELLS = 450;
    localparam int IDLE_PERCENT = 18;

    typedef logic signed [15:0]          cell_t;
    typedef logic signed [SUM_OUT_W-1:0] path_sum_t;
    typedef struct packed {
        logic [SUM_OUT_W-1:0] sum;
        logic [AVG_OUT_W-1:0] avg;
    } path_result_t;

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        grid_size_we = 1'b0;
    logic [CFG_W-1:0]            grid_size    = 7'd1;
    logic                        in_valid     = 1'b0;
    logic                        in_stall;
    cell_t                       cell_value   = '0;
    logic                        out_valid;
    logic                        out_stall    = 1'b0;
    path_sum_t                   best_path_sum;
    logic signed [AVG_OUT_W-1:0] average_q8;

    // Predictor state: best sums of the row above, the left neighbour and the cell position.
    path_sum_t        prev_row_best [MAX_SIDE];
    path_sum_t        left_sum      = '0;
    int unsigned      next_col      = 0;
    int unsigned      next_row      = 0;
    logic [CFG_W-1:0] size_setting  = 7'd1;

    path_result_t expected_paths [$];
    int           mismatch_count = 0;
    bit           steady         = 1'b0;
    int           hold_request   = 0;
    int           hold_left      = 0;
    int           random_sent    = 0;

    grid_max_average_path i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .grid_size_we  (grid_size_we),
        .grid_size     (grid_size),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cell_value    (cell_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .best_path_sum (best_path_sum),
        .average_q8    (average_q8)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("grid_max_average_path: mismatch");
        $finish;
    end

    function automatic int unsigned effective_side(input logic [CFG_W-1:0] setting);
        if (setting == 0)
            return 1;
        if (setting > MAX_SIDE)
            return MAX_SIDE;
        return int'(setting);
    endfunction

    function automatic void predict_cell(input cell_t value);
        int unsigned  n;
        longint       best;
        longint       above;
        longint       left;
        longint       denom;
        longint       avg;
        path_result_t res;
        n = effective_side(size_setting);
        if (next_col >= n || next_row >= n)
        begin
            next_col = 0;
            next_row = 0;
            left_sum = '0;
        end
        above = longint'(prev_row_best[next_col]);
        left  = longint'(left_sum);
        if (next_row == 0 && next_col == 0)
            best = longint'(value);
        else if (next_row == 0)
            best = left + value;
        else if (next_col == 0)
            best = above + value;
        else
            best = ((above > left) ? above : left) + value;
        prev_row_best[next_col] = path_sum_t'(best);
        left_sum = path_sum_t'(best);
        if (next_col + 1 < n)
        begin
            next_col++;
            return;
        end
        next_col = 0;
        if (next_row + 1 < n)
        begin
            next_row++;
            return;
        end
        next_row = 0;
        left_sum = '0;
        denom = longint'(2 * n - 1);
        avg = (best * (longint'(1) << FRAC_BITS)) / denom;
        res.sum = best[SUM_OUT_W-1:0];
        res.avg = avg[AVG_OUT_W-1:0];
        expected_paths.push_back(res);
    endfunction

    function automatic cell_t random_cell();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            return 16'sh8000;
        if (pick < 24)
            return 16'sh7fff;
        if (pick < 40)
            return cell_t'(int'($urandom_range(0, 16)) - 8);
        return cell_t'($urandom);
    endfunction

    task automatic report(input string text);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", text);
    endtask

    // Result checker: every accepted result is matched against the oldest expected one.
    always @(posedge clk)
    begin : check_result
        path_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_paths.size() == 0)
            begin
                report($sformatf("result with no request pending: sum %0d avg %0d",
                                 best_path_sum, average_q8));
            end
            else
            begin
                want = expected_paths.pop_front();
                if (best_path_sum !== want.sum)
                    report($sformatf("best_path_sum: expected %0d, got %0d",
                                     $signed(want.sum), best_path_sum));
                if (average_q8 !== want.avg)
                    report($sformatf("average_q8: expected %0d, got %0d",
                                     $signed(want.avg), average_q8));
            end
        end
    end

    // Receiver side: random stalls, or a long hold when one is requested.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    task automatic send_cell(input cell_t value);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid   <= 1'b0;
            cell_value <= cell_t'($urandom);
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        cell_value <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_cell(value);
    endtask

    task automatic send_random_cells(input int unsigned count);
        repeat (count)
        begin
            send_cell(random_cell());
            random_sent++;
        end
    endtask

    // Lets every pending result come out, then idles for the DRAIN_CYCLES drain period.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_paths.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_size(input logic [CFG_W-1:0] value);
        wait_idle();
        grid_size_we <= 1'b1;
        grid_size    <= value;
        @(posedge clk);
        grid_size_we <= 1'b0;
        size_setting = value;
        next_col     = 0;
        next_row     = 0;
        left_sum     = '0;
    endtask

    task automatic test_single_cells();
        cell_t picks [6];
        picks = '{16'sh8000, 16'sh7fff, 16'sh0000, -16'sd1, 16'sd1, 16'sh5555};
        foreach (picks[k])
            send_cell(picks[k]);
    endtask

    task automatic test_size_zero();
        write_size(7'd0);
        send_cell(16'sh8000);
        send_cell(16'sd12345);
    endtask

    task automatic test_small_grids();
        cell_t picks [9];
        write_size(7'd2);
        send_cell(16'sd100);
        send_cell(-16'sd5);
        send_cell(16'sd7);
        send_cell(16'sd3);
        // Values chosen so that the left predecessor wins or ties at each inner cell.
        picks = '{16'sd1, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sd5,
                  -16'sd1, 16'sd2, 16'sh7fff};
        write_size(7'd3);
        foreach (picks[k])
            send_cell(picks[k]);
    endtask

    task automatic test_size_rewrite();
        write_size(7'd127);
        send_random_cells(70);
        write_size(7'd65);
        send_random_cells(5);
        write_size(7'd2);
        send_random_cells(3);
        // Writing the same size again must restart the partial grid.
        write_size(7'd2);
        send_random_cells(4);
    endtask

    task automatic test_largest_grid();
        write_size(CFG_W'(BIG_SIDE));
        steady = 1'b1;
        repeat (BIG_SIDE * BIG_SIDE)
            send_cell(16'sh8000);
        wait_idle();
        steady = 1'b0;
    endtask

    task automatic test_backpressure();
        write_size(7'd1);
        hold_request = 400;
        send_random_cells(60);
        wait_idle();
    endtask

    task automatic test_random();
        int          phase;
        int unsigned pick;
        int unsigned n;
        phase       = 0;
        random_sent = 0;
        while (random_sent < RANDOM_CELLS)
        begin
            steady = (phase >= 2 && phase < 4);
            if ($urandom_range(0, 99) < 80)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    write_size(CFG_W'($urandom_range(1, 4)));
                else if (pick < 90)
                    write_size(CFG_W'($urandom_range(5, 10)));
                else
                    write_size(CFG_W'($urandom_range(11, 16)));
            end
            else if ($urandom_range(0, 1) == 0)
                wait_idle();
            n = effective_side(size_setting);
            if (n > 16)
                write_size(CFG_W'($urandom_range(1, 4)));
            n = effective_side(size_setting);
            repeat ($urandom_range(1, 4))
                send_random_cells(n * n);
            if (n > 1 && $urandom_range(0, 9) == 0)
                send_random_cells($urandom_range(1, n * n - 1));
            phase++;
        end
        steady = 1'b0;
    endtask

    initial
    begin
        foreach (prev_row_best[k])
            prev_row_best[k] = '0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_single_cells();
        test_size_zero();
        test_small_grids();
        test_size_rewrite();
        test_largest_grid();
        test_backpressure();
        test_random();
        wait_idle();
        if (mismatch_count == 0)
            $display("grid_max_average_path: match");
        else
            $display("grid_max_average_path: mismatch");
        $finish;
    end

endmodule
